// ===== hw/rtl/pn3_pkg.sv =====
// Package for the 3D gradient noise block: permutation table and its lookup
// function. Used by all pn3_* modules and the top level.
`timescale 1ns / 1ps
package pn3_pkg;

  localparam logic [7:0] PermRom [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,
    8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,
    8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,
    8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,
    8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,
    8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,
    8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,
    8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,
    8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,
    8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,
    8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,
    8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
    8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,
    8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
    8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,
    8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180};

  // 8 corners: index bit0 = x side, bit1 = y side, bit2 = z side
  localparam int unsigned NumCorners = 8;

  function automatic logic [7:0] perm(input logic [7:0] i);
    perm = PermRom[i];
  endfunction

endpackage

// ===== hw/rtl/perlin_noise_3d.sv =====
// Top level of the 3D gradient noise block: front, back, result queue.
// Depends on pn3_pkg, pn3_front, pn3_fifo, pn3_back.
//
//  channel | handshake         | payload
//  input   | push / full       | coord_x_i, coord_y_i, coord_z_i
//  result  | pop / empty       | noise_value_o
//
// One item per cycle while the pipelines are not halted; a result reaches the
// ports through two front stages, eleven back stages, then the queue write.
// Reset clears all valid bits and queue pointers; no table clearing.
// The pipelines advance together; they halt while the result queue holds three
// or more results and none is popped in that cycle.
`timescale 1ns / 1ps
module perlin_noise_3d #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [23:0]        coord_x_i,
  input  logic [23:0]        coord_y_i,
  input  logic [23:0]        coord_z_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] noise_value_o
);
  import pn3_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned Lat   = 13;

  logic                 en, f_vld, b_vld, q_empty;
  logic [FRAC_BITS-1:0] fx, fy, fz;
  logic [7:0]           hash [8];
  logic [15:0]          b_res;
  logic [15:0]          q_data;
  logic [$clog2(Depth):0] q_cnt;
  logic                 acc, deq;

  // Room for every item that may still be in the pipes.
  assign en   = (q_cnt <= ($clog2(Depth)+1)'(Depth - Lat - 1)) || deq;
  assign full = !en;
  assign acc  = push && !full;
  assign deq  = pop && !q_empty;

  pn3_front #(.FracBits(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(acc),
    .x_i(coord_x_i), .y_i(coord_y_i), .z_i(coord_z_i),
    .vld_o(f_vld), .fx_o(fx), .fy_o(fy), .fz_o(fz), .hash_o(hash)
  );

  pn3_back #(.FracBits(FRAC_BITS), .OutFracBits(OUT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld),
    .fx_i(fx), .fy_i(fy), .fz_i(fz), .hash_i(hash),
    .vld_o(b_vld), .res_o(b_res)
  );

  pn3_fifo #(.Width(16), .Depth(Depth)) u_q (
    .clk_i, .rst_ni, .wr_i(b_vld && en), .wdata_i(b_res),
    .rd_i(deq), .empty_o(q_empty), .rdata_o(q_data), .count_o(q_cnt)
  );

  assign empty         = q_empty;
  assign noise_value_o = q_data;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= ($clog2(Depth)+1)'(Depth)) else $error("result queue overflow");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !deq) else $error("pop on empty");
endmodule

// ===== hw/rtl/pn3_front.sv =====
// Front part: splits coordinates, hashes the eight corners, fade inputs.
// Two register stages; depends on pn3_pkg.
`timescale 1ns / 1ps
module pn3_front #(
  parameter int unsigned FracBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [23:0]          x_i,
  input  logic [23:0]          y_i,
  input  logic [23:0]          z_i,
  output logic                 vld_o,
  output logic [FracBits-1:0]  fx_o,
  output logic [FracBits-1:0]  fy_o,
  output logic [FracBits-1:0]  fz_o,
  output logic [7:0]           hash_o [8]
);
  import pn3_pkg::*;

  logic                vld1_q, vld2_q;
  logic [FracBits-1:0] fx1_q, fy1_q, fz1_q, fx2_q, fy2_q, fz2_q;
  logic [7:0]          a_q, b_q, zi1_q;
  logic [7:0]          hash_q [8];
  logic [7:0]          xi, yi, zi;
  logic [7:0]          c_aa, c_ab, c_ba, c_bb;

  assign xi = x_i[FracBits +: 8];
  assign yi = y_i[FracBits +: 8];
  assign zi = z_i[FracBits +: 8];

  assign c_aa = perm(a_q) + zi1_q;
  assign c_ab = perm(a_q + 8'd1) + zi1_q;
  assign c_ba = perm(b_q) + zi1_q;
  assign c_bb = perm(b_q + 8'd1) + zi1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx1_q <= x_i[FracBits-1:0];
      fy1_q <= y_i[FracBits-1:0];
      fz1_q <= z_i[FracBits-1:0];
      a_q   <= perm(xi) + yi;
      b_q   <= perm(xi + 8'd1) + yi;
      zi1_q <= zi;
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
      fz2_q <= fz1_q;
      hash_q[0] <= perm(c_aa);
      hash_q[1] <= perm(c_ba);
      hash_q[2] <= perm(c_ab);
      hash_q[3] <= perm(c_bb);
      hash_q[4] <= perm(c_aa + 8'd1);
      hash_q[5] <= perm(c_ba + 8'd1);
      hash_q[6] <= perm(c_ab + 8'd1);
      hash_q[7] <= perm(c_bb + 8'd1);
    end
  end

  assign vld_o  = vld2_q;
  assign fx_o   = fx2_q;
  assign fy_o   = fy2_q;
  assign fz_o   = fz2_q;
  assign hash_o = hash_q;
endmodule

// ===== hw/rtl/pn3_fifo.sv =====
// Short result queue after the back part, with an occupancy count.
// Depends on pn3_pkg for nothing but the house import style.
`timescale 1ns / 1ps
module pn3_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o,
  output logic [Aw:0]      count_o
);
  import pn3_pkg::*;

  logic [Width-1:0] mem [Depth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + {{Aw{1'b0}}, wr_i} - {{Aw{1'b0}}, rd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem[wp_q] <= wdata_i;
  end

  assign rdata_o = mem[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
endmodule

// ===== hw/rtl/pn3_back.sv =====
// Back part: fade curves, gradients, trilinear blend, output rounding.
// Pipelined; depends on pn3_pkg.
`timescale 1ns / 1ps
module pn3_back #(
  parameter int unsigned FracBits    = 16,
  parameter int unsigned OutFracBits = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [FracBits-1:0] fx_i,
  input  logic [FracBits-1:0] fy_i,
  input  logic [FracBits-1:0] fz_i,
  input  logic [7:0]          hash_i [8],
  output logic                vld_o,
  output logic signed [15:0]  res_o
);
  import pn3_pkg::*;

  // Signed working width: fade temps reach 15.0, so keep +-16 in fixed point.
  localparam int unsigned W  = FracBits + 5;
  localparam int unsigned Pw = 2 * W;
  localparam int unsigned Ns = 11;
  localparam logic signed [W-1:0] One = W'(1) <<< FracBits;

  function automatic logic signed [W-1:0] rnd(input logic signed [Pw-1:0] p);
    logic signed [Pw-1:0] q;
    q   = p + (Pw'(1) <<< (FracBits - 1));
    rnd = W'(q >>> FracBits);
  endfunction

  function automatic logic signed [W-1:0] grad(input logic [3:0] h,
      input logic signed [W-1:0] x, input logic signed [W-1:0] y,
      input logic signed [W-1:0] z);
    logic signed [W-1:0] u, v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    grad = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // pipe regs: t = fade inputs (x,y,z); c, t2, d, t3 = fade temps; g = corner values
  logic [Ns-1:0]       vld_q;
  logic signed [W-1:0] t_q [2][3];
  logic signed [W-1:0] c_q [3], t2_q [3], d_q [3], t3_q [3], f_q [3];
  logic signed [W-1:0] fv_q [2], fw_q [4];
  logic signed [W-1:0] g_q [8];
  logic signed [W-1:0] l1_q [4], l2_q [2], l3_q;
  logic signed [W-1:0] df1_q [4], df2_q [2], df3_q;
  logic signed [W-1:0] a1_q [4], a2_q [2], a3_q;
  logic signed [W-1:0] r_q;
  logic signed [15:0]  out_q;
  logic [7:0]          h_q [2][8];
  logic signed [W-1:0] fin;
  logic signed [Pw-1:0] fsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[Ns-2:0], vld_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // s0: capture
      t_q[0][0] <= W'(fx_i);
      t_q[0][1] <= W'(fy_i);
      t_q[0][2] <= W'(fz_i);
      h_q[0] <= hash_i;
      h_q[1] <= h_q[0];
      t_q[1] <= t_q[0];
      for (int k = 0; k < 3; k++) begin
        // s1: c = 15 - 6t ; t2 = t*t
        c_q[k]  <= W'(15) * One - W'(6) * t_q[0][k];
        t2_q[k] <= rnd(Pw'(t_q[0][k]) * Pw'(t_q[0][k]));
        // s2: d = t*c ; t3 = t2*t
        d_q[k]  <= rnd(Pw'(t_q[1][k]) * Pw'(c_q[k]));
        t3_q[k] <= rnd(Pw'(t2_q[k]) * Pw'(t_q[1][k]));
        // s3: fade
        f_q[k]  <= rnd(Pw'(t3_q[k]) * Pw'(W'(10) * One - d_q[k]));
      end
      // y and z fades wait for their blend stages
      fv_q[0] <= f_q[1];
      fv_q[1] <= fv_q[0];
      fw_q[0] <= f_q[2];
      for (int i = 1; i < 4; i++) fw_q[i] <= fw_q[i-1];
      // s2: gradients (x0/x1 etc.)
      for (int c = 0; c < 8; c++) begin
        g_q[c] <= grad(h_q[1][c][3:0],
                       c[0] ? t_q[1][0] - One : t_q[1][0],
                       c[1] ? t_q[1][1] - One : t_q[1][1],
                       c[2] ? t_q[1][2] - One : t_q[1][2]);
      end
      // s3: x differences
      for (int i = 0; i < 4; i++) begin
        a1_q[i]  <= g_q[2*i];
        df1_q[i] <= g_q[2*i+1] - g_q[2*i];
      end
      // s4: x blend
      for (int i = 0; i < 4; i++) l1_q[i] <= a1_q[i] + rnd(Pw'(df1_q[i]) * Pw'(f_q[0]));
      // s5
      for (int i = 0; i < 2; i++) begin
        a2_q[i]  <= l1_q[2*i];
        df2_q[i] <= l1_q[2*i+1] - l1_q[2*i];
      end
      // s6
      for (int i = 0; i < 2; i++) l2_q[i] <= a2_q[i] + rnd(Pw'(df2_q[i]) * Pw'(fv_q[1]));
      a3_q  <= l2_q[0];
      df3_q <= l2_q[1] - l2_q[0];
      l3_q  <= a3_q + rnd(Pw'(df3_q) * Pw'(fw_q[3]));
      r_q   <= l3_q;
      out_q <= 16'(fin);
    end
  end

  // output scaling and saturation
  always_comb begin
    fsh = Pw'(r_q);
    if (OutFracBits >= FracBits) fsh = fsh <<< (OutFracBits - FracBits);
    else fsh = (fsh + (Pw'(1) <<< (FracBits - OutFracBits - 1))) >>> (FracBits - OutFracBits);
    if (fsh > Pw'(32767)) fin = W'(32767);
    else if (fsh < -Pw'(32768)) fin = -W'(32768);
    else fin = W'(fsh);
  end

  // Eleven stages, s0 capture through the output register.
  assign vld_o = vld_q[Ns-1];
  assign res_o = out_q;
endmodule

// ===== tb/sv/perlin_noise_3d_tb.sv =====
// Testbench for perlin_noise_3d: computes the expected 3D gradient noise for
// each accepted coordinate and checks results in order. Depends on pn3_pkg.
`timescale 1ns / 1ps
module perlin_noise_3d_tb;
  import pn3_pkg::*;

  localparam int FracBits    = 16;
  localparam int OutFracBits = 14;
  localparam int Latency     = 40;
  localparam longint MaxCycles = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [23:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] noise_value_o;

  perlin_noise_3d u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .coord_x_i(coord_x_i), .coord_y_i(coord_y_i), .coord_z_i(coord_z_i),
    .empty(empty), .pop(pop), .noise_value_o(noise_value_o)
  );

  logic signed [15:0] noise_expected_q[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---- predictor ----
  function automatic longint rnd_shift(longint p, int s);
    longint q;
    if (s == 0) return p;
    q = p + (longint'(1) << (s - 1));
    return q >>> s;  // arithmetic shift equals floor
  endfunction

  function automatic longint fade_curve(longint t);
    longint one, d, t2, t3;
    one = longint'(1) << FracBits;
    d  = rnd_shift(t * (15 * one - 6 * t), FracBits);
    t2 = rnd_shift(t * t, FracBits);
    t3 = rnd_shift(t2 * t, FracBits);
    return rnd_shift(t3 * (10 * one - d), FracBits);
  endfunction

  function automatic longint grad_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint lerp_fx(longint a, longint b, longint s);
    return a + rnd_shift((b - a) * s, FracBits);
  endfunction

  function automatic logic signed [15:0] noise_at(logic [23:0] cx, logic [23:0] cy,
                                                    logic [23:0] cz);
    longint one, x, y, z, u, v, w, x1, y1, z1, n0, n1, r;
    logic [7:0] xi, yi, zi, a, aa, ab, b, ba, bb;
    one = longint'(1) << FracBits;
    xi = cx[FracBits +: 8]; yi = cy[FracBits +: 8]; zi = cz[FracBits +: 8];
    x = cx[FracBits-1:0]; y = cy[FracBits-1:0]; z = cz[FracBits-1:0];
    u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
    x1 = x - one; y1 = y - one; z1 = z - one;
    a  = PermRom[xi] + yi;
    aa = PermRom[a] + zi;
    ab = PermRom[8'(a + 1)] + zi;
    b  = PermRom[8'(xi + 1)] + yi;
    ba = PermRom[b] + zi;
    bb = PermRom[8'(b + 1)] + zi;
    n0 = lerp_fx(lerp_fx(grad_dot(PermRom[aa], x, y, z), grad_dot(PermRom[ba], x1, y, z), u),
                 lerp_fx(grad_dot(PermRom[ab], x, y1, z), grad_dot(PermRom[bb], x1, y1, z), u),
                 v);
    n1 = lerp_fx(lerp_fx(grad_dot(PermRom[8'(aa + 1)], x, y, z1),
                         grad_dot(PermRom[8'(ba + 1)], x1, y, z1), u),
                 lerp_fx(grad_dot(PermRom[8'(ab + 1)], x, y1, z1),
                         grad_dot(PermRom[8'(bb + 1)], x1, y1, z1), u), v);
    r = lerp_fx(n0, n1, w);
    r = rnd_shift(r, FracBits - OutFracBits);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // ---- request driver ----
  task automatic send_coord(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    coord_x_i <= cx; coord_y_i <= cy; coord_z_i <= cz;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    noise_expected_q.push_back(noise_at(cx, cy, cz));
    n_requests++;
  endtask

  task automatic go_idle();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    go_idle();
    while (noise_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // ---- result checker and receiver stalls ----
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (noise_expected_q.size() == 0) begin
          $display("%0t: unexpected result %0d", $time, noise_value_o);
          errors++;
        end else begin
          if (noise_value_o !== noise_expected_q[0]) begin
            $display("%0t: noise mismatch expected %0d actual %0d", $time,
                     noise_expected_q[0], noise_value_o);
            errors++;
          end
          void'(noise_expected_q.pop_front());
        end
        n_results++;
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(4))
      0: return 24'($urandom_range(3)) << FracBits | 24'($urandom_range(15));
      1: return {8'($urandom), 16'hFFFF - 16'($urandom_range(15))};
      default: return 24'($urandom);
    endcase
  endfunction

  // ---- tests ----
  task automatic test_directed();
    logic [23:0] corner[6];
    corner = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000, 24'h008000, 24'h7F4000};
    for (int i = 0; i < 6; i++) send_coord(corner[i], corner[(i+2)%6], corner[(i+4)%6]);
    // integer wrap at cell 255 and the lattice points themselves
    send_coord(24'hFF8000, 24'hFF8000, 24'hFF8000);
    send_coord(24'h010000, 24'h020000, 24'h030000);
    send_coord(24'h00FFFF, 24'h000001, 24'hFFFFFF);
    // walk many hash values to hit the gradient cases
    for (int i = 0; i < 16; i++) send_coord({8'(i * 17), 16'h4000}, {8'(i), 16'hC000},
                                            {8'(255 - i), 16'h2AAA});
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_coord(rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_pause_until_drained();
    test_random(20, 0, 30);
    drain();
    test_random(20, 0, 0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150, 0, 0);
    test_random(150, 64, 0);
    test_random(150, 0, 64);
    test_random(150, 36, 36);
    test_pause_until_drained();
    recv_stall_pct = 10;
    drain();
    repeat (Latency) @(posedge clk_i);
    $display("%0d coordinates sent, %0d noise values checked across idle and stall mixes",
             n_requests, n_results);
    if (errors == 0 && noise_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
